// ===== rtl/gblur_pkg.sv =====
package gblur_pkg;

    localparam int MAX_RADIUS_DEF = 8;
    localparam int MAX_WIDTH_DEF  = 64;
    localparam int MAX_HEIGHT_DEF = 64;

    localparam int COL_W  = 6;
    localparam int ROW_W  = 6;
    localparam int PIX_W  = 8;
    localparam int WIDX_W = 5;
    localparam int WGT_W  = 16;
    localparam int OP_W   = 2;

    // Weights are Q2.14, so the product of two carries 28 fraction bits.
    localparam int SUM_SHIFT = 28;

    localparam logic [OP_W-1:0] OP_WRITE_PIXEL  = 2'd0;
    localparam logic [OP_W-1:0] OP_WRITE_WEIGHT = 2'd1;
    localparam logic [OP_W-1:0] OP_READ_BLUR    = 2'd2;

    localparam logic [PIX_W-1:0] BYTE_MAX = 8'd255;

    // Register indexes on the configuration port.
    localparam logic [1:0] REG_BLUR_RADIUS   = 2'd0;
    localparam logic [1:0] REG_IMAGE_WIDTH   = 2'd1;
    localparam logic [1:0] REG_IMAGE_HEIGHT  = 2'd2;
    localparam logic [1:0] REG_ADDITIVE_MODE = 2'd3;

    typedef struct packed {
        logic load;      // latch read coordinates and window bounds
        logic issue;     // read one window pixel and advance
        logic pix_we;    // store a pixel
        logic wgt_we;    // store a weight
        logic out_load;  // move the finished sum into the output register
    } cmd_t;

    typedef struct packed {
        logic empty;     // clipped window holds no pixel
        logic last;      // current position is the window's last pixel
        logic pipe_busy; // terms still in the multiply pipeline
        logic out_free;  // output register can take a result
    } status_t;

endpackage

// ===== rtl/gblur_ctrl.sv =====
module gblur_ctrl (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        s_tvalid,
    output logic                        s_tready,
    input  logic [gblur_pkg::OP_W-1:0]  opcode,
    input  gblur_pkg::status_t          status,
    output gblur_pkg::cmd_t             cmd
);

    localparam logic [1:0] ST_IDLE  = 2'd0;
    localparam logic [1:0] ST_RUN   = 2'd1;
    localparam logic [1:0] ST_DRAIN = 2'd2;
    localparam logic [1:0] ST_DONE  = 2'd3;

    logic [1:0] state_reg;
    logic [1:0] state_next;

    assign s_tready = (state_reg == ST_IDLE);

    always_comb begin
        state_next = state_reg;
        cmd        = '0;
        unique case (state_reg)
            ST_IDLE: begin
                if (s_tvalid) begin
                    unique case (opcode)
                        gblur_pkg::OP_WRITE_PIXEL:  cmd.pix_we = 1'b1;
                        gblur_pkg::OP_WRITE_WEIGHT: cmd.wgt_we = 1'b1;
                        gblur_pkg::OP_READ_BLUR: begin
                            cmd.load   = 1'b1;
                            state_next = ST_RUN;
                        end
                        default: ;
                    endcase
                end
            end
            ST_RUN: begin
                if (status.empty) begin
                    state_next = ST_DRAIN;
                end else begin
                    cmd.issue = 1'b1;
                    if (status.last) begin
                        state_next = ST_DRAIN;
                    end
                end
            end
            ST_DRAIN: begin
                if (!status.pipe_busy) begin
                    state_next = ST_DONE;
                end
            end
            ST_DONE: begin
                // hold the sum until the output register frees up
                if (status.out_free) begin
                    cmd.out_load = 1'b1;
                    state_next   = ST_IDLE;
                end
            end
            default: state_next = ST_IDLE;
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= ST_IDLE;
        end else begin
            state_reg <= state_next;
        end
    end

endmodule

// ===== rtl/gblur_dpath.sv =====
module gblur_dpath #(
    parameter int MAX_RADIUS = gblur_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = gblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gblur_pkg::MAX_HEIGHT_DEF
) (
    input  logic                          aclk,
    input  logic                          aresetn,
    input  gblur_pkg::cmd_t               cmd,
    output gblur_pkg::status_t            status,
    input  logic [gblur_pkg::COL_W-1:0]   column,
    input  logic [gblur_pkg::ROW_W-1:0]   row,
    input  logic [gblur_pkg::PIX_W-1:0]   red_in,
    input  logic [gblur_pkg::PIX_W-1:0]   alpha_in,
    input  logic [gblur_pkg::WIDX_W-1:0]  weight_index,
    input  logic [gblur_pkg::WGT_W-1:0]   weight_value,
    input  logic [3:0]                    blur_radius,
    input  logic [6:0]                    image_width,
    input  logic [6:0]                    image_height,
    input  logic                          additive_mode,
    output logic                          m_tvalid,
    input  logic                          m_tready,
    output logic [gblur_pkg::PIX_W-1:0]   colour_out,
    output logic [gblur_pkg::PIX_W-1:0]   alpha_out
);

    localparam int WCOUNT = 2 * MAX_RADIUS + 1;
    localparam int WIW    = $clog2(WCOUNT);
    localparam int DEPTH  = MAX_WIDTH * MAX_HEIGHT;
    localparam int AW     = $clog2(DEPTH);
    localparam int XB     = ($clog2(MAX_WIDTH) > gblur_pkg::COL_W) ?
                            $clog2(MAX_WIDTH) : gblur_pkg::COL_W;
    localparam int YB     = ($clog2(MAX_HEIGHT) > gblur_pkg::ROW_W) ?
                            $clog2(MAX_HEIGHT) : gblur_pkg::ROW_W;
    localparam int XW     = XB + 1;
    localparam int YW     = YB + 1;
    localparam int PIX_W  = gblur_pkg::PIX_W;
    localparam int WGT_W  = gblur_pkg::WGT_W;
    localparam int PROD_W = 2 * WGT_W;
    localparam int TERM_W = PROD_W + PIX_W;
    localparam int ACC_W  = TERM_W + $clog2(WCOUNT * WCOUNT);
    localparam int SHIFT  = gblur_pkg::SUM_SHIFT;

    // window bounds for the incoming read item
    logic [XW-1:0]  cx, rx, wm1, xsum, x0, x1;
    logic [YW-1:0]  cy, ry, hm1, ysum, y0, y1;
    logic [WIW-1:0] ix0, iy0;

    always_comb begin
        cx = XW'(column);
        cy = YW'(row);
        rx = (blur_radius > MAX_RADIUS) ? XW'(MAX_RADIUS) : XW'(blur_radius);
        ry = (blur_radius > MAX_RADIUS) ? YW'(MAX_RADIUS) : YW'(blur_radius);
        if (image_width == '0) begin
            wm1 = '0;
        end else if (image_width > MAX_WIDTH) begin
            wm1 = XW'(MAX_WIDTH - 1);
        end else begin
            wm1 = XW'(image_width - 7'd1);
        end
        if (image_height == '0) begin
            hm1 = '0;
        end else if (image_height > MAX_HEIGHT) begin
            hm1 = YW'(MAX_HEIGHT - 1);
        end else begin
            hm1 = YW'(image_height - 7'd1);
        end
        xsum = cx + rx;
        ysum = cy + ry;
        x0   = (cx > rx) ? cx - rx : '0;
        y0   = (cy > ry) ? cy - ry : '0;
        x1   = (xsum < wm1) ? xsum : wm1;
        y1   = (ysum < hm1) ? ysum : hm1;
        ix0  = (cx > rx) ? '0 : WIW'(rx - cx);
        iy0  = (cy > ry) ? '0 : WIW'(ry - cy);
    end

    logic [XW-1:0]  x0_reg, x1_reg, x_reg;
    logic [YW-1:0]  y0_reg, y1_reg, y_reg;
    logic [WIW-1:0] iy0_reg, ix_reg, iy_reg;

    always_ff @(posedge aclk) begin
        if (cmd.load) begin
            x0_reg  <= x0;
            x1_reg  <= x1;
            y0_reg  <= y0;
            y1_reg  <= y1;
            iy0_reg <= iy0;
            x_reg   <= x0;
            y_reg   <= y0;
            ix_reg  <= ix0;
            iy_reg  <= iy0;
        end else if (cmd.issue) begin
            // column outer, row inner
            if (y_reg == y1_reg) begin
                y_reg  <= y0_reg;
                iy_reg <= iy0_reg;
                x_reg  <= x_reg + 1'b1;
                ix_reg <= ix_reg + 1'b1;
            end else begin
                y_reg  <= y_reg + 1'b1;
                iy_reg <= iy_reg + 1'b1;
            end
        end
    end

    // image and weight stores
    logic [PIX_W-1:0] pix_mem [DEPTH];
    logic [WGT_W-1:0] wgt_mem [WCOUNT];

    logic [AW-1:0]    wr_addr, rd_addr;
    logic             wr_in_range, widx_ok;
    logic [PIX_W-1:0] pix_wdata;
    logic [PIX_W-1:0] pix_q_reg;
    logic [WGT_W-1:0] wx_q_reg, wy_q_reg;

    assign wr_in_range = (column < MAX_WIDTH) && (row < MAX_HEIGHT);
    assign widx_ok     = (weight_index < WCOUNT);
    assign wr_addr     = AW'(row) * AW'(MAX_WIDTH) + AW'(column);
    assign rd_addr     = AW'(y_reg) * AW'(MAX_WIDTH) + AW'(x_reg);
    assign pix_wdata   = additive_mode ? red_in : alpha_in;

    always_ff @(posedge aclk) begin
        if (cmd.pix_we && wr_in_range) begin
            pix_mem[wr_addr] <= pix_wdata;
        end
        pix_q_reg <= pix_mem[rd_addr];
    end

    always_ff @(posedge aclk) begin
        if (cmd.wgt_we && widx_ok) begin
            wgt_mem[WIW'(weight_index)] <= weight_value;
        end
        wx_q_reg <= wgt_mem[ix_reg];
        wy_q_reg <= wgt_mem[iy_reg];
    end

    // multiply pipeline: weight product, then pixel term, then accumulate
    logic              v1_reg, v2_reg, v3_reg;
    logic [PROD_W-1:0] wprod_reg;
    logic [PIX_W-1:0]  pix2_reg;
    logic [TERM_W-1:0] term_reg;
    logic [ACC_W-1:0]  acc_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            v1_reg <= 1'b0;
            v2_reg <= 1'b0;
            v3_reg <= 1'b0;
        end else begin
            v1_reg <= cmd.issue;
            v2_reg <= v1_reg;
            v3_reg <= v2_reg;
        end
    end

    always_ff @(posedge aclk) begin
        wprod_reg <= wx_q_reg * wy_q_reg;
        pix2_reg  <= pix_q_reg;
        term_reg  <= wprod_reg * pix2_reg;
        if (cmd.load) begin
            acc_reg <= '0;
        end else if (v3_reg) begin
            acc_reg <= acc_reg + ACC_W'(term_reg);
        end
    end

    logic [PIX_W-1:0] blur_val;

    assign blur_val = (acc_reg[ACC_W-1:SHIFT+PIX_W] != '0) ? gblur_pkg::BYTE_MAX
                                                          : acc_reg[SHIFT+PIX_W-1:SHIFT];

    // output register
    logic             out_valid_reg;
    logic [PIX_W-1:0] colour_reg, alpha_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            out_valid_reg <= 1'b0;
        end else if (cmd.out_load) begin
            out_valid_reg <= 1'b1;
        end else if (m_tready) begin
            out_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge aclk) begin
        if (cmd.out_load) begin
            colour_reg <= additive_mode ? blur_val : gblur_pkg::BYTE_MAX;
            alpha_reg  <= additive_mode ? gblur_pkg::BYTE_MAX : blur_val;
        end
    end

    assign m_tvalid   = out_valid_reg;
    assign colour_out = colour_reg;
    assign alpha_out  = alpha_reg;

    assign status.empty     = (x0_reg > x1_reg) || (y0_reg > y1_reg);
    assign status.last      = (x_reg == x1_reg) && (y_reg == y1_reg);
    assign status.pipe_busy = v1_reg || v2_reg || v3_reg;
    assign status.out_free  = !out_valid_reg || m_tready;

    a_issue_nonempty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> !status.empty)
        else $error("window read issued for an empty window");

    a_issue_in_window: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.issue |-> (x_reg <= x1_reg && y_reg <= y1_reg &&
                       ix_reg < WCOUNT && iy_reg < WCOUNT))
        else $error("window position or weight index out of range");

    a_result_after_drain: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.out_load |-> !status.pipe_busy)
        else $error("result taken while terms still in flight");

    a_load_pipe_empty: assert property (@(posedge aclk) disable iff (!aresetn)
        cmd.load |-> !status.pipe_busy)
        else $error("new read started with terms of the previous one in flight");

endmodule

// ===== rtl/glyph_gaussian_blur_core.sv =====
// Glyph blur core: holds a glyph image of one byte per pixel and a table of
// 2R+1 separable Q2.14 weights, both loaded by write items; a read item returns
// the weighted sum over the square window of radius R around the pixel,
// clipped at the image edges and not renormalized, shifted right by 28 and
// saturated to 255. Write items return nothing. A read item runs one
// multiply-accumulate per window pixel through the single pixel-store read
// port, plus the fill and drain of the three-stage multiply pipeline. Items
// are taken one at a time; a finished result waits in the output register,
// and the next items are accepted meanwhile. Stored pixels and weights are
// undefined until written.
module glyph_gaussian_blur_core #(
    parameter int MAX_RADIUS = gblur_pkg::MAX_RADIUS_DEF,
    parameter int MAX_WIDTH  = gblur_pkg::MAX_WIDTH_DEF,
    parameter int MAX_HEIGHT = gblur_pkg::MAX_HEIGHT_DEF
) (
    input  logic        aclk,
    input  logic        aresetn,

    input  logic        s_tvalid,
    output logic        s_tready,
    // column[5:0], row[11:6], red_in[19:12], alpha_in[27:20],
    // weight_index[32:28], weight_value[48:33], zero[55:49]
    input  logic [55:0] s_tdata,
    // opcode[1:0]
    input  logic [1:0]  s_tuser,

    output logic        m_tvalid,
    input  logic        m_tready,
    // colour_out[7:0], alpha_out[15:8]
    output logic [15:0] m_tdata,

    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [3:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);

    // configuration registers
    logic [3:0] blur_radius_reg;
    logic [6:0] image_width_reg;
    logic [6:0] image_height_reg;
    logic       additive_mode_reg;
    logic       cfg_we;
    logic [1:0] cfg_idx;

    assign pready  = 1'b1;
    assign cfg_we  = psel && penable && pwrite && pready;
    assign cfg_idx = paddr[3:2];

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            blur_radius_reg   <= 4'd1;
            image_width_reg   <= 7'd64;
            image_height_reg  <= 7'd64;
            additive_mode_reg <= 1'b0;
        end else if (cfg_we) begin
            unique case (cfg_idx)
                gblur_pkg::REG_BLUR_RADIUS:   blur_radius_reg   <= pwdata[3:0];
                gblur_pkg::REG_IMAGE_WIDTH:   image_width_reg   <= pwdata[6:0];
                gblur_pkg::REG_IMAGE_HEIGHT:  image_height_reg  <= pwdata[6:0];
                gblur_pkg::REG_ADDITIVE_MODE: additive_mode_reg <= pwdata[0];
                default: ;
            endcase
        end
    end

    always_comb begin
        unique case (cfg_idx)
            gblur_pkg::REG_BLUR_RADIUS:   prdata = 32'(blur_radius_reg);
            gblur_pkg::REG_IMAGE_WIDTH:   prdata = 32'(image_width_reg);
            gblur_pkg::REG_IMAGE_HEIGHT:  prdata = 32'(image_height_reg);
            gblur_pkg::REG_ADDITIVE_MODE: prdata = 32'(additive_mode_reg);
            default:                      prdata = '0;
        endcase
    end

    gblur_pkg::cmd_t    cmd;
    gblur_pkg::status_t status;
    logic [7:0]         colour_out;
    logic [7:0]         alpha_out;

    gblur_ctrl u_ctrl (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .opcode   (s_tuser),
        .status   (status),
        .cmd      (cmd)
    );

    gblur_dpath #(
        .MAX_RADIUS (MAX_RADIUS),
        .MAX_WIDTH  (MAX_WIDTH),
        .MAX_HEIGHT (MAX_HEIGHT)
    ) u_dpath (
        .aclk          (aclk),
        .aresetn       (aresetn),
        .cmd           (cmd),
        .status        (status),
        .column        (s_tdata[5:0]),
        .row           (s_tdata[11:6]),
        .red_in        (s_tdata[19:12]),
        .alpha_in      (s_tdata[27:20]),
        .weight_index  (s_tdata[32:28]),
        .weight_value  (s_tdata[48:33]),
        .blur_radius   (blur_radius_reg),
        .image_width   (image_width_reg),
        .image_height  (image_height_reg),
        .additive_mode (additive_mode_reg),
        .m_tvalid      (m_tvalid),
        .m_tready      (m_tready),
        .colour_out    (colour_out),
        .alpha_out     (alpha_out)
    );

    assign m_tdata = {alpha_out, colour_out};

endmodule
